// ===== rtl/wsts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsts_pkg
// shared types, codes and the gamma decode table of the texture sampler
// ----------------------------------------------------------------------------
package wsts_pkg;

    localparam int TEXEL_DEPTH_DEF = 262144;
    localparam int QUEUE_DEPTH     = 4;
    localparam int ADDR_W          = 22;   // row * width + column before reduction
    localparam int RECIP_SHIFT     = 22;

    // input kinds carried in tuser
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // configuration register indexes
    localparam logic REG_RASTER_WIDTH  = 1'b0;
    localparam logic REG_RASTER_HEIGHT = 1'b1;

    // one job handed from front to back
    typedef struct packed {
        logic                    sample;
        logic                    empty;
        logic [31:0]             word;
        logic [3:0][ADDR_W-1:0]  addr;   // 00, 10, 01, 11; writes use entry 0
        logic [16:0]             wx;
        logic [16:0]             wy;
    } t_job;

    typedef logic [15:0] t_gamma_lut [256];

    function automatic t_gamma_lut gamma_lut_build();
        t_gamma_lut lut;
        longint     v;
        for (int i = 0; i < 256; i++) begin
            v = (longint'(i) * longint'(i) * 65535 + 32512) / 65025;
            lut[i] = 16'(v);
        end
        return lut;
    endfunction

    localparam t_gamma_lut GAMMA_LUT = gamma_lut_build();

endpackage
`default_nettype wire

// ===== rtl/wsts_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsts_front
// accepts words, places coordinates, builds weights and store addresses
// ----------------------------------------------------------------------------
module wsts_front #(
    parameter int TEXEL_DEPTH = wsts_pkg::TEXEL_DEPTH_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_wr_en,
    input  wire logic         i_cfg_index,
    input  wire logic [10:0]  i_cfg_data,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic         i_action,
    input  wire logic [17:0]  i_index,
    input  wire logic [31:0]  i_word,
    input  wire logic [15:0]  i_lon,
    input  wire logic [16:0]  i_colat,
    output logic              o_push,
    output wsts_pkg::t_job    o_job,
    input  wire logic         i_full
);

    localparam int AW = wsts_pkg::ADDR_W;
    localparam logic [20:0]   RECIP   = 21'((64'd1 << wsts_pkg::RECIP_SHIFT) / TEXEL_DEPTH);
    localparam logic [AW-1:0] DEPTH_A = AW'(TEXEL_DEPTH);

    logic [10:0] r_width, r_height;
    logic        en;

    // stage registers
    logic [6:0]  r_v;
    logic        r_f0_smp; logic [17:0] r_f0_idx; logic [31:0] r_f0_word;
    logic [15:0] r_f0_lon; logic [16:0] r_f0_colat;
    logic        r_f1_smp, r_f1_emp; logic [17:0] r_f1_idx; logic [31:0] r_f1_word;
    logic [27:0] r_f1_px;  logic [28:0] r_f1_py;
    logic        r_f2_smp, r_f2_emp; logic [17:0] r_f2_idx; logic [31:0] r_f2_word;
    logic [10:0] r_f2_x0, r_f2_x1, r_f2_y0, r_f2_y1;
    logic [31:0] r_f2_sqx, r_f2_sqy; logic [17:0] r_f2_mx, r_f2_my;
    logic        r_f3_smp, r_f3_emp; logic [17:0] r_f3_idx; logic [31:0] r_f3_word;
    logic [10:0] r_f3_x0, r_f3_x1; logic [AW-1:0] r_f3_y0w, r_f3_y1w;
    logic [16:0] r_f3_wx, r_f3_wy;
    logic        r_f4_smp, r_f4_emp; logic [31:0] r_f4_word; logic [AW-1:0] r_f4_a [4];
    logic [16:0] r_f4_wx, r_f4_wy;
    logic        r_f5_smp, r_f5_emp; logic [31:0] r_f5_word; logic [AW-1:0] r_f5_a [4];
    logic [AW-1:0] r_f5_q [4]; logic [16:0] r_f5_wx, r_f5_wy;
    logic        r_f6_smp, r_f6_emp; logic [31:0] r_f6_word; logic [AW-1:0] r_f6_r [4];
    logic [16:0] r_f6_wx, r_f6_wy;

    // combinational split of positions
    logic [11:0] xi; logic [12:0] yi, y0t; logic [10:0] hm;
    logic [10:0] n_x0, n_x1, n_y0, n_y1;
    logic [49:0] prod_x, prod_y;

    assign en      = !r_v[6] || !i_full;
    assign o_ready = en;
    assign o_push  = r_v[6] && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= '0;
            r_height <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                wsts_pkg::REG_RASTER_WIDTH:  r_width  <= i_cfg_data;
                wsts_pkg::REG_RASTER_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[5:0], i_valid};
        end
    end

    always_comb begin
        xi  = r_f1_px[27:16];
        yi  = r_f1_py[28:16];
        hm  = r_height - 11'd1;
        n_x0 = (xi == 12'd0) ? r_width - 11'd1 : 11'(xi - 12'd1);
        n_x1 = (xi == {1'b0, r_width}) ? 11'd0 : xi[10:0];
        y0t  = (yi == 13'd0) ? 13'd0 : yi - 13'd1;
        n_y0 = (y0t > {2'b00, hm}) ? hm : y0t[10:0];
        n_y1 = (yi > {2'b00, hm}) ? hm : yi[10:0];
        prod_x = 50'(r_f2_sqx) * 50'(r_f2_mx) + 50'h0_0000_8000_0000;
        prod_y = 50'(r_f2_sqy) * 50'(r_f2_my) + 50'h0_0000_8000_0000;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // f0: capture
            r_f0_smp   <= (i_action == wsts_pkg::ACT_SAMPLE);
            r_f0_idx   <= i_index;
            r_f0_word  <= i_word;
            r_f0_lon   <= i_lon;
            r_f0_colat <= i_colat;
            // f1: pixel-centre positions
            r_f1_smp  <= r_f0_smp;
            r_f1_emp  <= (r_width == 11'd0) || (r_height == 11'd0);
            r_f1_idx  <= r_f0_idx;
            r_f1_word <= r_f0_word;
            r_f1_px   <= 28'(r_f0_lon) * 28'(r_width) + 28'h0008000;
            r_f1_py   <= 29'(r_f0_colat) * 29'(r_height) + 29'h0008000;
            // f2: neighbours and squared fractions
            r_f2_smp  <= r_f1_smp;
            r_f2_emp  <= r_f1_emp;
            r_f2_idx  <= r_f1_idx;
            r_f2_word <= r_f1_word;
            r_f2_x0   <= n_x0;
            r_f2_x1   <= n_x1;
            r_f2_y0   <= n_y0;
            r_f2_y1   <= n_y1;
            r_f2_sqx  <= 32'(r_f1_px[15:0]) * 32'(r_f1_px[15:0]);
            r_f2_sqy  <= 32'(r_f1_py[15:0]) * 32'(r_f1_py[15:0]);
            r_f2_mx   <= 18'd196608 - {1'b0, r_f1_px[15:0], 1'b0};
            r_f2_my   <= 18'd196608 - {1'b0, r_f1_py[15:0], 1'b0};
            // f3: smoothstep weights and row offsets
            r_f3_smp  <= r_f2_smp;
            r_f3_emp  <= r_f2_emp;
            r_f3_idx  <= r_f2_idx;
            r_f3_word <= r_f2_word;
            r_f3_x0   <= r_f2_x0;
            r_f3_x1   <= r_f2_x1;
            r_f3_y0w  <= AW'(r_f2_y0) * AW'(r_width);
            r_f3_y1w  <= AW'(r_f2_y1) * AW'(r_width);
            r_f3_wx   <= prod_x[48:32];
            r_f3_wy   <= prod_y[48:32];
            // f4: linear addresses, write index on lane 0
            r_f4_smp  <= r_f3_smp;
            r_f4_emp  <= r_f3_emp;
            r_f4_word <= r_f3_word;
            r_f4_a[0] <= r_f3_smp ? r_f3_y0w + AW'(r_f3_x0) : AW'(r_f3_idx);
            r_f4_a[1] <= r_f3_y0w + AW'(r_f3_x1);
            r_f4_a[2] <= r_f3_y1w + AW'(r_f3_x0);
            r_f4_a[3] <= r_f3_y1w + AW'(r_f3_x1);
            r_f4_wx   <= r_f3_wx;
            r_f4_wy   <= r_f3_wy;
            // f5: quotient estimate by reciprocal
            r_f5_smp  <= r_f4_smp;
            r_f5_emp  <= r_f4_emp;
            r_f5_word <= r_f4_word;
            r_f5_wx   <= r_f4_wx;
            r_f5_wy   <= r_f4_wy;
            for (int k = 0; k < 4; k++) begin
                r_f5_a[k] <= r_f4_a[k];
                r_f5_q[k] <= AW'((44'(r_f4_a[k]) * 44'(RECIP)) >> wsts_pkg::RECIP_SHIFT);
            end
            // f6: remainder, at most one depth too large
            r_f6_smp  <= r_f5_smp;
            r_f6_emp  <= r_f5_emp;
            r_f6_word <= r_f5_word;
            r_f6_wx   <= r_f5_wx;
            r_f6_wy   <= r_f5_wy;
            for (int k = 0; k < 4; k++) begin
                r_f6_r[k] <= r_f5_a[k] - AW'(44'(r_f5_q[k]) * 44'(DEPTH_A));
            end
        end
    end

    always_comb begin
        o_job.sample = r_f6_smp;
        o_job.empty  = r_f6_emp;
        o_job.word   = r_f6_word;
        o_job.wx     = r_f6_wx;
        o_job.wy     = r_f6_wy;
        for (int k = 0; k < 4; k++) begin
            o_job.addr[k] = (r_f6_r[k] >= DEPTH_A) ? r_f6_r[k] - DEPTH_A : r_f6_r[k];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/wsts_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsts_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module wsts_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire wsts_pkg::t_job  i_job,
    input  wire logic            i_pop,
    output wsts_pkg::t_job       o_job,
    output logic                 o_full,
    output logic                 o_empty
);

    localparam int PW = $clog2(wsts_pkg::QUEUE_DEPTH);

    wsts_pkg::t_job r_slot [wsts_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [PW:0]    r_count;

    assign o_full  = (r_count == (PW+1)'(wsts_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + PW'(1);
            if (i_pop)  r_rd <= r_rd + PW'(1);
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (PW+1)'(1);
                2'b01:   r_count <= r_count - (PW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr] <= i_job;
    end

endmodule
`default_nettype wire

// ===== rtl/wsts_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsts_back
// texel store, gamma decode and two-step blend
// ----------------------------------------------------------------------------
module wsts_back #(
    parameter int TEXEL_DEPTH = wsts_pkg::TEXEL_DEPTH_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire wsts_pkg::t_job  i_job,
    input  wire logic            i_empty,
    output logic                 o_pop,
    output logic                 m_axis_tvalid,
    input  wire logic            m_axis_tready,
    output logic [63:0]          m_axis_tdata
);

    localparam int MW = $clog2(TEXEL_DEPTH);

    // four copies, one per neighbour, all written alike
    logic [31:0] mem0 [TEXEL_DEPTH];
    logic [31:0] mem1 [TEXEL_DEPTH];
    logic [31:0] mem2 [TEXEL_DEPTH];
    logic [31:0] mem3 [TEXEL_DEPTH];

    logic        en;
    logic [2:0]  r_v;
    logic        r_m_smp, r_m_emp; logic [16:0] r_m_wx, r_m_wy;
    logic [31:0] r_m_rd [4];
    logic        r_d_smp, r_d_emp; logic [16:0] r_d_wx, r_d_wy;
    logic [15:0] r_d_ch [4][4];
    logic        r_h_smp, r_h_emp; logic [16:0] r_h_wy;
    logic [15:0] r_h_top [4], r_h_bot [4];
    logic [15:0] vout [4];

    function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                          input logic [16:0] w);
        logic signed [16:0] d;
        logic signed [35:0] p;
        logic signed [19:0] s;
        d = $signed({1'b0, b}) - $signed({1'b0, a});
        p = d * $signed({1'b0, w}) + 36'sd32768;
        s = 20'(p >>> 16);
        return 16'($signed({4'b0000, a}) + s);
    endfunction

    assign en    = !m_axis_tvalid || m_axis_tready;
    assign o_pop = en && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[1:0], o_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && !i_job.sample) begin
            mem0[i_job.addr[0][MW-1:0]] <= i_job.word;
            mem1[i_job.addr[0][MW-1:0]] <= i_job.word;
            mem2[i_job.addr[0][MW-1:0]] <= i_job.word;
            mem3[i_job.addr[0][MW-1:0]] <= i_job.word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_rd[0] <= mem0[i_job.addr[0][MW-1:0]];
            r_m_rd[1] <= mem1[i_job.addr[1][MW-1:0]];
            r_m_rd[2] <= mem2[i_job.addr[2][MW-1:0]];
            r_m_rd[3] <= mem3[i_job.addr[3][MW-1:0]];
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            vout[c] = blend(r_h_top[c], r_h_bot[c], r_h_wy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_smp <= i_job.sample;
            r_m_emp <= i_job.empty;
            r_m_wx  <= i_job.wx;
            r_m_wy  <= i_job.wy;
            // gamma 2 decode on colour, coverage times 257
            r_d_smp <= r_m_smp;
            r_d_emp <= r_m_emp;
            r_d_wx  <= r_m_wx;
            r_d_wy  <= r_m_wy;
            for (int t = 0; t < 4; t++) begin
                r_d_ch[t][0] <= wsts_pkg::GAMMA_LUT[r_m_rd[t][7:0]];
                r_d_ch[t][1] <= wsts_pkg::GAMMA_LUT[r_m_rd[t][15:8]];
                r_d_ch[t][2] <= wsts_pkg::GAMMA_LUT[r_m_rd[t][23:16]];
                r_d_ch[t][3] <= {r_m_rd[t][31:24], r_m_rd[t][31:24]};
            end
            // longitude blend
            r_h_smp <= r_d_smp;
            r_h_emp <= r_d_emp;
            r_h_wy  <= r_d_wy;
            for (int c = 0; c < 4; c++) begin
                r_h_top[c] <= blend(r_d_ch[0][c], r_d_ch[1][c], r_d_wx);
                r_h_bot[c] <= blend(r_d_ch[2][c], r_d_ch[3][c], r_d_wx);
            end
            m_axis_tdata <= r_h_emp ? 64'd0 : {vout[3], vout[2], vout[1], vout[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (en) begin
            m_axis_tvalid <= r_v[2] && r_h_smp;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/wrapped_smoothstep_texture_sampler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrapped_smoothstep_texture_sampler
// equirectangular rgba8 texture store with smoothstep-weighted bilinear sampling
// ----------------------------------------------------------------------------
//  channel   direction  handshake                      contents
//  s_axis    in         s_axis_tvalid / s_axis_tready  texel writes and sample requests
//  m_axis    out        m_axis_tvalid / m_axis_tready  one linear rgba word per sample
//  cfg       in         i_cfg_wr_en                    raster width (0), height (1)
//
//  one word accepted per cycle while not stalled; a sample result passes through
//  7 front stages, the queue, store read, decode and two blend stages
//  reset clears control and the raster size; store contents stay undefined
//  the front stalls only when the queue is full, the back only when m_axis stalls
// ----------------------------------------------------------------------------
module wrapped_smoothstep_texture_sampler #(
    parameter int TEXEL_DEPTH = wsts_pkg::TEXEL_DEPTH_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // configuration writes
    input  wire logic         i_cfg_wr_en,
    input  wire logic         i_cfg_index,
    input  wire logic [10:0]  i_cfg_data,
    // input words
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [87:0]  s_axis_tdata,  // texel_index, texel_word, lon_turn, colat_frac, pad
    input  wire logic         s_axis_tuser,  // action
    // result words
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [63:0]       m_axis_tdata   // red, green, blue, coverage
);

    logic            q_push, q_pop, q_full, q_empty;
    wsts_pkg::t_job  q_in, q_out;

    // address generation and weights
    wsts_front #(.TEXEL_DEPTH(TEXEL_DEPTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_action    (s_axis_tuser),
        .i_index     (s_axis_tdata[17:0]),
        .i_word      (s_axis_tdata[49:18]),
        .i_lon       (s_axis_tdata[65:50]),
        .i_colat     (s_axis_tdata[82:66]),
        .o_push      (q_push),
        .o_job       (q_in),
        .i_full      (q_full)
    );

    // decouples the two pipelines
    wsts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .i_pop   (q_pop),
        .o_job   (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // store, decode and blend
    wsts_back #(.TEXEL_DEPTH(TEXEL_DEPTH)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (q_out),
        .i_empty       (q_empty),
        .o_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // queue never written when full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full) else $error("job queue overflow");

    // queue never read when empty
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty) else $error("job queue underflow");

    // reduced addresses stay inside the store
    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_in.addr[0] < TEXEL_DEPTH) && (!q_in.sample ||
            ((q_in.addr[1] < TEXEL_DEPTH) && (q_in.addr[2] < TEXEL_DEPTH) &&
             (q_in.addr[3] < TEXEL_DEPTH)))) else $error("store address out of range");

endmodule
`default_nettype wire
